// ----- src/png_rf_pkg.sv -----
// ----------------------------------------------------------------------------
// png_rf_pkg
// Shared types and constants of the PNG row filter with row cost.
// ----------------------------------------------------------------------------
package png_rf_pkg;

   localparam int MAX_ROW_BYTES   = 8192;
   localparam int MAX_PIXEL_BYTES = 8;

   localparam int BYTE_W      = 8;
   localparam int FILTER_W    = 3;
   localparam int BPP_W       = 4;
   localparam int ROW_BYTES_W = 14;
   localparam int COST_W      = 21;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = ROW_BYTES_W;

   localparam logic [BPP_W-1:0]       BPP_RESET       = 4'd3;
   localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 14'd1920;

   // register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_BPP       = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_BYTES = 2'd1;

   typedef enum logic [FILTER_W-1:0] {
      FILT_NONE        = 3'd0,
      FILT_SUB         = 3'd1,
      FILT_UP          = 3'd2,
      FILT_AVG         = 3'd3,
      FILT_PAETH       = 3'd4,
      FILT_AVG_FIRST   = 3'd5,
      FILT_PAETH_FIRST = 3'd6
   } filter_type;

   // payload of the filter stage
   typedef struct packed {
      logic [BYTE_W-1:0]   pixel_byte;
      logic [FILTER_W-1:0] filter;
      logic                has_left;
      logic                row_end;
   } stage_type;

endpackage

// ----- src/png_rf_line_store.sv -----
// ----------------------------------------------------------------------------
// png_rf_line_store
// Previous-row byte store: one write and one registered read per cycle,
// with a bypass for a read that meets a write to the same address.
// ----------------------------------------------------------------------------
module png_rf_line_store #(
   parameter int Depth = png_rf_pkg::MAX_ROW_BYTES,
   parameter int AddrW = $clog2(png_rf_pkg::MAX_ROW_BYTES)
)(
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [AddrW-1:0]              rd_addr,
   input  logic                          wr_en,
   input  logic [AddrW-1:0]              wr_addr,
   input  logic [png_rf_pkg::BYTE_W-1:0] wr_data,
   output logic [png_rf_pkg::BYTE_W-1:0] rd_data
);
   import png_rf_pkg::*;

   logic [BYTE_W-1:0] mem [Depth];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] byp_data_ff;
   logic              byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_data_ff;

endmodule

// ----- src/png_rf_predict.sv -----
// ----------------------------------------------------------------------------
// png_rf_predict
// Predictor select (none, sub, up, average, Paeth), residual and magnitude.
// ----------------------------------------------------------------------------
module png_rf_predict (
   input  logic [png_rf_pkg::FILTER_W-1:0] filter,
   input  logic [png_rf_pkg::BYTE_W-1:0]   pixel_byte,
   input  logic [png_rf_pkg::BYTE_W-1:0]   left,
   input  logic [png_rf_pkg::BYTE_W-1:0]   up,
   input  logic [png_rf_pkg::BYTE_W-1:0]   upleft,
   output logic [png_rf_pkg::BYTE_W-1:0]   residual,
   output logic [png_rf_pkg::BYTE_W-1:0]   magnitude
);
   import png_rf_pkg::*;

   logic [BYTE_W-1:0] pa;
   logic [BYTE_W-1:0] pb;
   logic [BYTE_W+1:0] pc;
   logic [BYTE_W+1:0] sum_ab;
   logic [BYTE_W+1:0] twice_c;
   logic [BYTE_W:0]   avg_sum;
   logic [BYTE_W-1:0] paeth;
   logic [BYTE_W-1:0] pred;

   // Paeth distances, p = a + b - c
   always_comb begin
      pa      = (up > upleft) ? up - upleft : upleft - up;
      pb      = (left > upleft) ? left - upleft : upleft - left;
      sum_ab  = (BYTE_W+2)'(left) + (BYTE_W+2)'(up);
      twice_c = {1'b0, upleft, 1'b0};
      pc      = (sum_ab > twice_c) ? sum_ab - twice_c : twice_c - sum_ab;
      if (((BYTE_W+2)'(pa) <= (BYTE_W+2)'(pb)) && ((BYTE_W+2)'(pa) <= pc)) begin
         paeth = left;
      end else if ((BYTE_W+2)'(pb) <= pc) begin
         paeth = up;
      end else begin
         paeth = upleft;
      end
   end

   always_comb begin
      avg_sum = (BYTE_W+1)'(left) + (BYTE_W+1)'(up);
      case (filter_type'(filter))
         FILT_SUB:         pred = left;
         FILT_UP:          pred = up;
         FILT_AVG:         pred = avg_sum[BYTE_W:1];
         FILT_PAETH:       pred = paeth;
         FILT_AVG_FIRST:   pred = {1'b0, left[BYTE_W-1:1]};
         FILT_PAETH_FIRST: pred = left;
         default:          pred = '0;
      endcase
      residual  = pixel_byte - pred;
      // -128 counts as 128, which still fits eight bits unsigned
      magnitude = residual[BYTE_W-1] ? BYTE_W'(8'd0 - residual) : residual;
   end

endmodule

// ----- src/png_row_filter_with_cost_top.sv -----
// ----------------------------------------------------------------------------
// png_row_filter_with_cost_top
// PNG scanline filter producing per-byte residuals and a running row cost.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one raw image byte and its filter code per transaction.
//   rsp_*  : residual (wrapped signed byte), running sum of absolute
//            residuals of the row, and a row_end flag on the last byte.
//   csr_*  : register writes (0 bytes_per_pixel, 1 row_bytes); always
//            ready, and meant to be written only while the block is idle.
// The accepting edge loads the filter stage and the line store read; the
// output register is loaded from the filter stage when that stage moves
// on. Throughput is one byte per cycle while rsp_ready stays high; the line
// store has one read and one write port, and a same-address read/write pair
// is bypassed.
// A stalled receiver holds the output register; the filter stage then
// fills, and req_ready drops only when both stages are full.
// Reset clears the column, cost, neighbor history and valid flags and
// loads the register defaults; the line store content is left as is.
// ----------------------------------------------------------------------------
module png_row_filter_with_cost_top #(
   parameter int MaxRowBytes   = png_rf_pkg::MAX_ROW_BYTES,
   parameter int MaxPixelBytes = png_rf_pkg::MAX_PIXEL_BYTES
)(
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [png_rf_pkg::BYTE_W-1:0]     req_pixel_byte,
   input  logic [png_rf_pkg::FILTER_W-1:0]   req_filter,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [png_rf_pkg::BYTE_W-1:0] rsp_residual,
   output logic [png_rf_pkg::COST_W-1:0]     rsp_row_cost,
   output logic                              rsp_row_end,
   // configuration port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [png_rf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [png_rf_pkg::CSR_DATA_W-1:0] csr_data
);
   import png_rf_pkg::*;

   localparam int ColW    = $clog2(MaxRowBytes);
   localparam int LenW    = (ColW + 1 > ROW_BYTES_W) ? ColW + 1 : ROW_BYTES_W;
   localparam int BppW    = BPP_W + 1;
   localparam int PixIdxW = (MaxPixelBytes > 1) ? $clog2(MaxPixelBytes) : 1;

   // configuration
   logic [BPP_W-1:0]       bpp_ff;
   logic [ROW_BYTES_W-1:0] row_bytes_ff;

   // row position, accept side
   logic [ColW-1:0] column_ff, column_in;

   // filter stage
   logic            s1_valid_ff;
   stage_type       s1_ff;
   logic [ColW-1:0] s1_col_ff;

   // row state, filter side
   logic [BYTE_W-1:0] left_ff   [MaxPixelBytes];
   logic [BYTE_W-1:0] upleft_ff [MaxPixelBytes];
   logic [COST_W-1:0] cost_ff, cost_in;

   // output register
   logic                     rsp_valid_ff;
   logic [BYTE_W-1:0]        rsp_residual_ff;
   logic [COST_W-1:0]        rsp_row_cost_ff;
   logic                     rsp_row_end_ff;

   logic [LenW-1:0]    len_ext, max_len, eff_len, bpp_len;
   logic [BppW-1:0]    bpp_ext, max_bpp, eff_bpp;
   logic [PixIdxW-1:0] pix_idx;
   logic               req_fire, s1_fire, row_end_now, has_left_now;
   logic [BYTE_W-1:0]  up_byte, left_byte, upleft_byte, residual, magnitude;
   logic [COST_W:0]    cost_sum;
   logic [COST_W-1:0]  cost_sat;
   stage_type          s1_in;

   // --- register clamping: zero acts as one, oversize as the maximum ---
   always_comb begin
      len_ext = LenW'(row_bytes_ff);
      max_len = LenW'(MaxRowBytes);
      if (row_bytes_ff == '0) begin
         eff_len = LenW'(1);
      end else if (len_ext > max_len) begin
         eff_len = max_len;
      end else begin
         eff_len = len_ext;
      end
      bpp_ext = BppW'(bpp_ff);
      max_bpp = BppW'(MaxPixelBytes);
      if (bpp_ff == '0) begin
         eff_bpp = BppW'(1);
      end else if (bpp_ext > max_bpp) begin
         eff_bpp = max_bpp;
      end else begin
         eff_bpp = bpp_ext;
      end
      bpp_len = LenW'(eff_bpp);
      pix_idx = PixIdxW'(eff_bpp - BppW'(1));
   end

   // --- handshakes ---
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= BPP_RESET;
         row_bytes_ff <= ROW_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_addr)
            CSR_BPP:       bpp_ff       <= csr_data[BPP_W-1:0];
            CSR_ROW_BYTES: row_bytes_ff <= csr_data[ROW_BYTES_W-1:0];
            default:       ;
         endcase
      end
   end

   // --- accept side: column tracking, line store read issue ---
   // a shortened row length ends the row as soon as the column reaches it
   always_comb begin
      row_end_now  = (LenW'(column_ff) + LenW'(1)) >= eff_len;
      has_left_now = LenW'(column_ff) >= bpp_len;
      column_in    = row_end_now ? '0 : column_ff + ColW'(1);
      s1_in.pixel_byte = req_pixel_byte;
      s1_in.filter     = req_filter;
      s1_in.has_left   = has_left_now;
      s1_in.row_end    = row_end_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else if (req_fire) begin
         column_ff <= column_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff     <= s1_in;
         s1_col_ff <= column_ff;
      end
   end

   // previous row; the filter stage writes its byte back as it leaves
   png_rf_line_store #(
      .Depth (MaxRowBytes),
      .AddrW (ColW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (column_ff),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (s1_ff.pixel_byte),
      .rd_data (up_byte)
   );

   // --- filter stage ---
   assign left_byte   = s1_ff.has_left ? left_ff[pix_idx] : '0;
   assign upleft_byte = s1_ff.has_left ? upleft_ff[pix_idx] : '0;

   png_rf_predict u_predict (
      .filter     (s1_ff.filter),
      .pixel_byte (s1_ff.pixel_byte),
      .left       (left_byte),
      .up         (up_byte),
      .upleft     (upleft_byte),
      .residual   (residual),
      .magnitude  (magnitude)
   );

   // saturating row cost
   always_comb begin
      cost_sum = (COST_W+1)'(cost_ff) + (COST_W+1)'(magnitude);
      cost_sat = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
      cost_in  = s1_ff.row_end ? '0 : cost_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff <= '0;
      end else if (s1_fire) begin
         cost_ff <= cost_in;
      end
   end

   // neighbor history, newest byte at index 0; cleared at row end
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxPixelBytes; i++) begin
            left_ff[i]   <= '0;
            upleft_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         if (s1_ff.row_end) begin
            for (int i = 0; i < MaxPixelBytes; i++) begin
               left_ff[i]   <= '0;
               upleft_ff[i] <= '0;
            end
         end else begin
            for (int i = MaxPixelBytes - 1; i > 0; i--) begin
               left_ff[i]   <= left_ff[i-1];
               upleft_ff[i] <= upleft_ff[i-1];
            end
            left_ff[0]   <= s1_ff.pixel_byte;
            upleft_ff[0] <= up_byte;
         end
      end
   end

   // --- output register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_residual_ff <= residual;
         rsp_row_cost_ff <= cost_sat;
         rsp_row_end_ff  <= s1_ff.row_end;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_residual = rsp_residual_ff;
   assign rsp_row_cost = rsp_row_cost_ff;
   assign rsp_row_end  = rsp_row_end_ff;

endmodule
